// File: rtl/core/psbc_pkg.sv
// Shared types and codes for the priority size budget cache.
`default_nettype none
package psbc_pkg;
   localparam int KeyW    = 32;
   localparam int BytesW  = 24;
   localparam int PrioW   = 8;
   localparam int TotalW  = 32;
   localparam int BudgetW = 11;
   localparam int MbShift = 20;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic KIND_EVICT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [KeyW-1:0]          key;
      logic [BytesW-1:0]        nbytes;
      logic signed [PrioW-1:0]  prio;
   } entry_type;

   localparam int EntryW = $bits(entry_type);
endpackage
`default_nettype wire

// File: rtl/core/psbc_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module psbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 33
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/priority_size_budget_cache_core.sv
// Priority ordered object cache with a byte budget, table kept in a RAM ring.
//
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tuser: opcode; tdata: key, bytes, priority
//  rsp     | out | tvalid/tready/tlast| tuser: kind; tdata: key, was, now, total
//  csr     | in  | wr_en              | wr_data: budget in megabytes
//
// One transaction at a time. A request scans all N resident entries, an insert
// then shifts the entries above its slot (one per cycle) and writes it; every
// eviction reads the ring head and waits for the rsp to be taken.
// Reset is synchronous; the table RAM is never cleared, only the count, head and total.
// A stalled rsp holds the block in place until the result is taken.
`default_nettype none
module priority_size_budget_cache_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // key[31:0], bytes[55:32], priority[63:56]
   input  wire logic [0:0]  req_tuser,   // opcode[0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata,   // key[31:0], was[32], now[33], total[65:34], 0
   output      logic [0:0]  rsp_tuser,   // kind[0]
   output      logic        rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [psbc_pkg::BudgetW-1:0] csr_wr_data
);
   import psbc_pkg::*;

   localparam int Slots = TABLE_DEPTH + 1;
   localparam int AW    = $clog2(Slots);
   localparam int CW    = $clog2(TABLE_DEPTH + 2);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_INS    = 3'd4;
   localparam logic [2:0] S_CHK    = 3'd5;
   localparam logic [2:0] S_EVRD   = 3'd6;
   localparam logic [2:0] S_WAIT   = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [BudgetW-1:0] budget_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [TotalW-1:0]  total_ff, total_in;
   logic               op_ff, op_in;
   entry_type          new_ff, new_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               pos_hit_ff, pos_hit_in;
   logic               found_ff, found_in;
   logic [CW-1:0]      newpos_ff, newpos_in;
   logic               live_ff, live_in;
   logic               done_ff, done_in;
   logic               ovalid_ff, ovalid_in;
   logic               okind_ff, okind_in;
   logic [KeyW-1:0]    okey_ff, okey_in;
   logic               owas_ff, owas_in;
   logic               onow_ff, onow_in;
   logic [TotalW-1:0]  oocc_ff, oocc_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   entry_type          wr_data, rd_data;
   logic [EntryW-1:0]  rd_raw;
   logic [TotalW-1:0]  budget_bytes;
   logic               over;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] lidx);
      logic [CW:0] s;
      s = (CW+1)'(head) + (CW+1)'(lidx);
      if (s >= (CW+1)'(Slots)) begin
         s = s - (CW+1)'(Slots);
      end
      return s[AW-1:0];
   endfunction

   psbc_ram #(.WIDTH(EntryW), .DEPTH(Slots)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_data = rd_raw;

   assign budget_bytes = TotalW'({budget_ff, {MbShift{1'b0}}});
   assign over = (count_ff != '0) &&
                 ((total_ff > budget_bytes) || (count_ff > CW'(TABLE_DEPTH)));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = okind_ff;
   assign rsp_tdata  = {6'd0, oocc_ff, onow_ff, owas_ff, okey_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      total_in   = total_ff;
      op_in      = op_ff;
      new_in     = new_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      pos_hit_in = pos_hit_ff;
      found_in   = found_ff;
      newpos_in  = newpos_ff;
      live_in    = live_ff;
      done_in    = done_ff;
      ovalid_in  = ovalid_ff;
      okind_in   = okind_ff;
      okey_in    = okey_ff;
      owas_in    = owas_ff;
      onow_in    = onow_ff;
      oocc_in    = oocc_ff;
      wr_en      = 1'b0;
      wr_addr    = phys(head_ff, idx_ff);
      wr_data    = new_ff;
      rd_addr    = phys(head_ff, '0);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser[0];
               new_in.key    = req_tdata[31:0];
               new_in.nbytes = req_tdata[55:32];
               new_in.prio   = req_tdata[63:56];
               idx_in     = '0;
               pos_in     = count_ff;
               pos_hit_in = 1'b0;
               found_in   = 1'b0;
               rd_addr    = phys(head_ff, '0);
               state_in   = (count_ff == '0) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_data.key == new_ff.key) begin
               found_in = 1'b1;
            end
            if (!pos_hit_ff && (rd_data.prio > new_ff.prio)) begin
               pos_in     = idx_ff;
               pos_hit_in = 1'b1;
            end
            if (idx_ff + 1'b1 < count_ff) begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = phys(head_ff, idx_ff + 1'b1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_LOOKUP || found_ff) begin
               ovalid_in = 1'b1;
               okind_in  = KIND_STATUS;
               okey_in   = new_ff.key;
               owas_in   = found_ff;
               onow_in   = found_ff;
               oocc_in   = total_ff;
               done_in   = 1'b1;
               state_in  = S_WAIT;
            end else if (count_ff > pos_ff) begin
               rd_addr  = phys(head_ff, count_ff - 1'b1);
               idx_in   = count_ff;
               state_in = S_SHIFT;
            end else begin
               state_in = S_INS;
            end
         end
         S_SHIFT: begin
            // read data is entry idx-1; it moves up to idx
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff);
            wr_data = rd_data;
            idx_in  = idx_ff - 1'b1;
            if (idx_ff - 1'b1 > pos_ff) begin
               rd_addr = phys(head_ff, idx_ff - 2'd2);
            end else begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            wr_en     = 1'b1;
            wr_addr   = phys(head_ff, pos_ff);
            wr_data   = new_ff;
            count_in  = count_ff + 1'b1;
            total_in  = total_ff + TotalW'(new_ff.nbytes);
            newpos_in = pos_ff;
            live_in   = 1'b1;
            state_in  = S_CHK;
         end
         S_CHK: begin
            if (over) begin
               rd_addr  = head_ff;
               state_in = S_EVRD;
            end else begin
               ovalid_in = 1'b1;
               okind_in  = KIND_STATUS;
               okey_in   = new_ff.key;
               owas_in   = 1'b0;
               onow_in   = live_ff;
               oocc_in   = total_ff;
               done_in   = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_EVRD: begin
            total_in  = total_ff - TotalW'(rd_data.nbytes);
            count_in  = count_ff - 1'b1;
            head_in   = phys(head_ff, CW'(1));
            ovalid_in = 1'b1;
            okind_in  = KIND_EVICT;
            okey_in   = rd_data.key;
            owas_in   = !(live_ff && newpos_ff == '0);
            onow_in   = 1'b0;
            oocc_in   = total_ff - TotalW'(rd_data.nbytes);
            done_in   = 1'b0;
            if (newpos_ff == '0) begin
               live_in = 1'b0;
            end else begin
               newpos_in = newpos_ff - 1'b1;
            end
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_tready) begin
               ovalid_in = 1'b0;
               state_in  = done_ff ? S_IDLE : S_CHK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         budget_ff <= BudgetW'(16);
         count_ff  <= '0;
         head_ff   <= '0;
         total_ff  <= '0;
         ovalid_ff <= 1'b0;
         live_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         count_ff  <= count_in;
         head_ff   <= head_in;
         total_ff  <= total_in;
         ovalid_ff <= ovalid_in;
         live_ff   <= live_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      new_ff     <= new_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      pos_hit_ff <= pos_hit_in;
      found_ff   <= found_in;
      newpos_ff  <= newpos_in;
      okind_ff   <= okind_in;
      okey_ff    <= okey_in;
      owas_ff    <= owas_in;
      onow_ff    <= onow_in;
      oocc_ff    <= oocc_in;
   end

   // table never holds more than its depth between transactions
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (count_ff <= CW'(TABLE_DEPTH)))
      else $error("entry count above depth while idle");

   // a result is only presented while waiting for it to be taken
   a_valid_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == S_WAIT))
      else $error("rsp valid outside wait state");

   // a finished request returns to idle once its status is taken
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (state_ff == S_IDLE))
      else $error("status taken but block not idle");
endmodule
`default_nettype wire
